FILE: rtl/imma_pkg.sv
// imma_pkg: shared types and constants for the integer matrix multiply-accumulate core
// no dependencies
package imma_pkg;
   localparam int MAX_DIM = 16;
   localparam int IDX_W = 4;
   localparam int DIM_W = 5;
   localparam int ADDR_W = 8;
   localparam int DATA_W = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [2:0] ACT_WRITE_A = 3'd0;
   localparam logic [2:0] ACT_WRITE_B = 3'd1;
   localparam logic [2:0] ACT_WRITE_C = 3'd2;
   localparam logic [2:0] ACT_COMPUTE = 3'd3;
   localparam logic [2:0] ACT_READ_C = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BETA = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INNER = 3'd4;

   typedef struct packed {
      logic [2:0] action;
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] col_index;
      logic signed [DATA_W-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic result_kind;
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
      logic signed [DATA_W-1:0] out_value;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic wr_c;
      logic rd_c;
      logic [ADDR_W-1:0] addr;
      logic clr_acc;
      logic [IDX_W-1:0] mi;
      logic [IDX_W-1:0] mj;
      logic [IDX_W-1:0] ml;
      logic mac_en;
      logic fin_rd;
      logic fin_mul;
      logic fin_wr;
   } dp_cmd_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      clamp_dim = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
   endfunction
endpackage

FILE: rtl/imma_datapath.sv
// imma_datapath: A, B, C stores, multiply-accumulate unit and beta/alpha update
// depends on imma_pkg
module imma_datapath (
   input  logic clock,
   input  logic [imma_pkg::DATA_W-1:0] alpha,
   input  logic [imma_pkg::DATA_W-1:0] beta,
   input  logic [imma_pkg::DATA_W-1:0] wdata,
   input  imma_pkg::dp_cmd_type cmd,
   output logic [imma_pkg::DATA_W-1:0] rdata
);
   logic [imma_pkg::DATA_W-1:0] a_mem [0:imma_pkg::MAX_DIM*imma_pkg::MAX_DIM-1];
   logic [imma_pkg::DATA_W-1:0] b_mem [0:imma_pkg::MAX_DIM*imma_pkg::MAX_DIM-1];
   logic [imma_pkg::DATA_W-1:0] c_mem [0:imma_pkg::MAX_DIM*imma_pkg::MAX_DIM-1];
   logic [imma_pkg::DATA_W-1:0] a_q_ff, b_q_ff, c_q_ff;
   logic [imma_pkg::DATA_W-1:0] prod_ff, acc_ff, acc_in;
   logic [imma_pkg::DATA_W-1:0] ta_ff, tb_ff, wb_ff;
   logic [imma_pkg::ADDR_W-1:0] a_ra, b_ra;

   assign a_ra = {cmd.mi, cmd.ml};
   assign b_ra = {cmd.ml, cmd.mj};

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem[cmd.addr] <= wdata;
      end
      if (cmd.wr_b) begin
         b_mem[cmd.addr] <= wdata;
      end
      a_q_ff <= a_mem[a_ra];
      b_q_ff <= b_mem[b_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_c) begin
         c_mem[cmd.addr] <= wdata;
      end else if (cmd.fin_wr) begin
         c_mem[{cmd.mi, cmd.mj}] <= wb_ff;
      end
      c_q_ff <= c_mem[cmd.rd_c ? cmd.addr : {cmd.mi, cmd.mj}];
   end

   assign acc_in = cmd.clr_acc ? '0 : (cmd.mac_en ? acc_ff + prod_ff : acc_ff);

   always_ff @(posedge clock) begin
      prod_ff <= a_q_ff * b_q_ff;
      acc_ff <= acc_in;
      if (cmd.fin_mul) begin
         ta_ff <= alpha * acc_ff;
         tb_ff <= beta * c_q_ff;
      end
      wb_ff <= ta_ff + tb_ff;
   end

   assign rdata = c_q_ff;
endmodule

FILE: rtl/imma_ctrl.sv
// imma_ctrl: sequencer for loads, reads and the i/j/l compute loops
// depends on imma_pkg
module imma_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  imma_pkg::req_type req,
   input  logic [imma_pkg::DIM_W-1:0] rows,
   input  logic [imma_pkg::DIM_W-1:0] cols,
   input  logic [imma_pkg::DIM_W-1:0] inner,
   input  logic [imma_pkg::DATA_W-1:0] rdata,
   output logic busy,
   output imma_pkg::dp_cmd_type cmd,
   output logic rsp_valid,
   output imma_pkg::rsp_type rsp
);
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_MAC  = 7'b0000100,
      ST_DRN  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_ADD  = 7'b0100000,
      ST_WR   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [imma_pkg::DIM_W-1:0] m_ff, n_ff, k_ff;
   logic [imma_pkg::DIM_W-1:0] i_ff, j_ff, l_ff, i_in, j_in, l_in;
   logic [1:0] dr_ff, dr_in;
   logic [1:0] v_ff, v_in;
   logic rvld_ff, rvld_in, rkind_ff, rkind_in, rrng_ff;
   logic [imma_pkg::IDX_W-1:0] rrow_ff, rcol_ff;
   logic go;

   assign go = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; l_in = l_ff; dr_in = dr_ff;
      v_in = {v_ff[0], 1'b0};
      rvld_in = 1'b0; rkind_in = 1'b0;
      cmd = '0;
      cmd.addr = {req.row_index, req.col_index};
      cmd.mi = i_ff[imma_pkg::IDX_W-1:0];
      cmd.mj = j_ff[imma_pkg::IDX_W-1:0];
      cmd.ml = l_ff[imma_pkg::IDX_W-1:0];
      cmd.mac_en = v_ff[1];
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               case (req.action)
                  imma_pkg::ACT_WRITE_A: cmd.wr_a = 1'b1;
                  imma_pkg::ACT_WRITE_B: cmd.wr_b = 1'b1;
                  imma_pkg::ACT_WRITE_C: cmd.wr_c = 1'b1;
                  imma_pkg::ACT_READ_C: begin
                     cmd.rd_c = 1'b1;
                     state_in = ST_READ;
                  end
                  imma_pkg::ACT_COMPUTE: begin
                     i_in = '0; j_in = '0; l_in = '0;
                     cmd.clr_acc = 1'b1;
                     state_in = ST_MAC;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_c = 1'b1;
            cmd.addr = {rrow_ff, rcol_ff};
            rvld_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MAC: begin
            if (m_ff == '0 || n_ff == '0) begin
               rvld_in = 1'b1; rkind_in = 1'b1;
               state_in = ST_IDLE;
            end else if (l_ff < k_ff) begin
               v_in = {v_ff[0], 1'b1};
               l_in = l_ff + 1'b1;
            end else begin
               dr_in = 2'd0;
               state_in = ST_DRN;
            end
         end
         ST_DRN: begin
            dr_in = dr_ff + 1'b1;
            if (dr_ff == 2'd2) begin
               cmd.fin_mul = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ADD;
         ST_ADD: state_in = ST_WR;
         ST_WR: begin
            cmd.fin_wr = 1'b1;
            cmd.clr_acc = 1'b1;
            l_in = '0;
            state_in = ST_MAC;
            if (j_ff + 1'b1 < n_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               j_in = '0;
               if (i_ff + 1'b1 < m_ff) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  rvld_in = 1'b1; rkind_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rvld_ff <= 1'b0;
         v_ff <= '0;
      end else begin
         state_ff <= state_in;
         rvld_ff <= rvld_in;
         v_ff <= v_in;
      end
      i_ff <= i_in; j_ff <= j_in; l_ff <= l_in; dr_ff <= dr_in;
      rkind_ff <= rkind_in;
      if (go) begin
         m_ff <= imma_pkg::clamp_dim(rows);
         n_ff <= imma_pkg::clamp_dim(cols);
         k_ff <= imma_pkg::clamp_dim(inner);
         rrow_ff <= req.row_index;
         rcol_ff <= req.col_index;
         rrng_ff <= 1'b1;
      end
   end

   assign rsp_valid = rvld_ff;
   assign rsp.result_kind = rkind_ff;
   assign rsp.out_row = rkind_ff ? '0 : rrow_ff;
   assign rsp.out_col = rkind_ff ? '0 : rcol_ff;
   assign rsp.out_value = (rkind_ff || !rrng_ff) ? '0 : rdata;

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      rvld_ff |-> state_ff == ST_IDLE) else $error("response outside idle");
   a_mac_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> l_ff <= k_ff) else $error("inner index overrun");
   a_wr_from_add: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR |-> $past(state_ff) == ST_ADD) else $error("bad writeback order");
endmodule

FILE: rtl/int_matrix_multiply_accumulate_core.sv
// int_matrix_multiply_accumulate_core: top level, csr file, controller and datapath
// depends on imma_pkg, imma_ctrl, imma_datapath
//
// channel | ports                              | handshake
// req     | start, busy, req_word              | taken when start && !busy
// rsp     | rsp_valid, rsp_word                | one-cycle strobe, no backpressure
// csr     | csr_write_en, csr_index, csr_wdata | taken when csr_write_en
//
// writes of A, B, C finish in idle; a read of C answers via the read state from the
// registered C store; compute runs the i/j/l loops, then drain, scale and writeback
// per C element on the single multiply-accumulate unit; m or n of 0 answers without computing
// reset clears control, sets alpha 1, beta 0, dims 16; stores undefined until written
// the receiver cannot stall; start waits only while busy
module int_matrix_multiply_accumulate_core (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  imma_pkg::req_type req_word,
   output logic busy,
   output logic rsp_valid,
   output imma_pkg::rsp_type rsp_word,
   input  logic csr_write_en,
   input  logic [imma_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [imma_pkg::DATA_W-1:0] csr_wdata
);
   logic [imma_pkg::DATA_W-1:0] alpha_ff, beta_ff, rdata;
   logic [imma_pkg::DIM_W-1:0] rows_ff, cols_ff, inner_ff;
   imma_pkg::dp_cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 32'd1;
         beta_ff <= '0;
         rows_ff <= 5'd16;
         cols_ff <= 5'd16;
         inner_ff <= 5'd16;
      end else if (csr_write_en) begin
         case (csr_index)
            imma_pkg::REG_ALPHA: alpha_ff <= csr_wdata;
            imma_pkg::REG_BETA: beta_ff <= csr_wdata;
            imma_pkg::REG_ROWS: rows_ff <= csr_wdata[imma_pkg::DIM_W-1:0];
            imma_pkg::REG_COLS: cols_ff <= csr_wdata[imma_pkg::DIM_W-1:0];
            imma_pkg::REG_INNER: inner_ff <= csr_wdata[imma_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   imma_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req(req_word),
      .rows(rows_ff), .cols(cols_ff), .inner(inner_ff), .rdata(rdata),
      .busy(busy), .cmd(cmd), .rsp_valid(rsp_valid), .rsp(rsp_word)
   );

   imma_datapath u_dp (
      .clock(clock), .alpha(alpha_ff), .beta(beta_ff),
      .wdata(req_word.elem_value), .cmd(cmd), .rdata(rdata)
   );
endmodule
